/* sv/gcsp_pkg.sv */
package gcsp_pkg;

    // result kinds
    typedef enum logic [2:0] {
        EV_BP   = 3'd0,
        EV_CP   = 3'd1,
        EV_XF   = 3'd2,
        EV_TRI  = 3'd3,
        EV_QUAD = 3'd4,
        EV_ERR  = 3'd5
    } t_event_kind;

    // one result item
    typedef struct packed {
        t_event_kind kind;
        logic [15:0] addr;
        logic [31:0] data;
        logic [2:0]  fmt;
        logic [15:0] cnt;
    } t_event;

    // front status seen by the top level checks
    typedef struct packed {
        logic halted;
        logic push;
        logic err;
    } t_front_status;

    localparam logic [7:0] OP_NOP_A   = 8'h00;
    localparam logic [7:0] OP_NOP_B   = 8'h48;
    localparam logic [7:0] OP_BP      = 8'h61;
    localparam logic [4:0] GRP_TRI    = 5'h12;
    localparam logic [4:0] GRP_QUAD   = 5'h10;
    localparam logic [4:0] GRP_CP     = 5'h01;
    localparam logic [4:0] GRP_XF     = 5'h02;

    // bytes per coordinate component by format code
    function automatic logic [2:0] f_coord(input logic [2:0] c);
        unique case (c)
            3'd0, 3'd1: f_coord = 3'd1;
            3'd2, 3'd3: f_coord = 3'd2;
            default:    f_coord = 3'd4;
        endcase
    endfunction

    // bytes per color by format code
    function automatic logic [2:0] f_color(input logic [2:0] c);
        unique case (c)
            3'd0, 3'd3: f_color = 3'd2;
            3'd1, 3'd4: f_color = 3'd3;
            default:    f_color = 3'd4;
        endcase
    endfunction

    // vertex size in bytes from descriptor and attribute registers
    function automatic logic [6:0] f_vertex_bytes(input logic [31:0] d1,
                                                  input logic [31:0] d2,
                                                  input logic [31:0] va);
        logic [7:0] sz;
        logic [1:0] m;
        sz = 8'($countones(d1[8:0]));
        m = d1[10:9];
        if (m != 2'd0)
            sz = sz + ((m >= 2'd2) ? 8'(m - 2'd1)
                                   : 8'(f_coord(va[3:1])) * (va[0] ? 8'd3 : 8'd2));
        m = d1[12:11];
        if (m != 2'd0)
            sz = sz + ((m >= 2'd2) ? 8'(m - 2'd1) * (va[31] ? 8'd3 : 8'd1)
                                   : 8'(f_coord(va[12:10])) * (va[9] ? 8'd9 : 8'd3));
        m = d1[14:13];
        if (m != 2'd0)
            sz = sz + ((m >= 2'd2) ? 8'(m - 2'd1) : 8'(f_color(va[16:14])));
        m = d1[16:15];
        if (m != 2'd0)
            sz = sz + ((m >= 2'd2) ? 8'(m - 2'd1) : 8'(f_color(va[20:18])));
        m = d2[1:0];
        if (m != 2'd0)
            sz = sz + ((m >= 2'd2) ? 8'(m - 2'd1)
                                   : 8'(f_coord(va[24:22])) * (va[21] ? 8'd2 : 8'd1));
        f_vertex_bytes = sz[6:0];
    endfunction

endpackage

/* sv/gcsp_front.sv */
module gcsp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_space,
    input  logic [7:0]             i_cmd_byte,
    output logic                   o_ready,
    output logic                   o_push,
    output gcsp_pkg::t_event       o_event,
    output gcsp_pkg::t_front_status o_status
);
    import gcsp_pkg::*;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_BP       = 9'b000000010,
        PH_CP       = 9'b000000100,
        PH_XF_HDR   = 9'b000001000,
        PH_XF_DATA  = 9'b000010000,
        PH_TRI_HDR  = 9'b000100000,
        PH_QUAD_HDR = 9'b001000000,
        PH_TRI_PAY  = 9'b010000000,
        PH_QUAD_PAY = 9'b100000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [39:0] r_hdr, n_hdr;
    logic [2:0]  r_pos, n_pos;
    logic [22:0] r_rem, n_rem;
    logic [4:0]  r_left, n_left;
    logic [15:0] r_xaddr, n_xaddr;
    logic        r_halted, n_halted;

    // descriptor and attribute registers that set vertex size
    logic [31:0] r_desc1 [8];
    logic [31:0] r_desc2 [8];
    logic [31:0] r_attr  [8];
    logic [6:0]  r_vsize [8];
    logic        r_recalc;
    logic [2:0]  r_recalc_fmt;

    logic        accept;
    logic        push;
    t_event      ev;
    logic [39:0] hdr_sh;
    logic [2:0]  pos_inc;
    logic [22:0] rem_dec;
    logic [4:0]  left_dec;
    logic [22:0] total;
    logic        cp_done;
    logic [7:0]  cp_idx;
    logic [4:0]  grp;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign hdr_sh  = {r_hdr[31:0], i_cmd_byte};
    assign pos_inc = r_pos + 3'd1;
    assign rem_dec = r_rem - 23'd1;
    assign left_dec = r_left - 5'd1;
    assign total   = 23'(hdr_sh[15:0]) * 23'(r_vsize[hdr_sh[18:16]]);
    assign cp_idx  = hdr_sh[39:32];
    assign grp     = i_cmd_byte[7:3];

    // byte parse step
    always_comb begin
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_pos    = r_pos;
        n_rem    = r_rem;
        n_left   = r_left;
        n_xaddr  = r_xaddr;
        n_halted = r_halted;
        push     = 1'b0;
        cp_done  = 1'b0;
        ev       = '0;
        if (accept && !r_halted) begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_hdr = '0;
                    n_pos = '0;
                    priority if (i_cmd_byte == OP_NOP_A || i_cmd_byte == OP_NOP_B) begin
                    end else if (i_cmd_byte == OP_BP) begin
                        n_phase = PH_BP;
                    end else if (grp == GRP_TRI || grp == GRP_QUAD) begin
                        n_phase = (grp == GRP_TRI) ? PH_TRI_HDR : PH_QUAD_HDR;
                        n_hdr   = {37'd0, i_cmd_byte[2:0]};
                    end else if (grp == GRP_CP) begin
                        n_phase = PH_CP;
                    end else if (grp == GRP_XF) begin
                        n_phase = PH_XF_HDR;
                    end else begin
                        n_halted = 1'b1;
                        push     = 1'b1;
                        ev.kind  = EV_ERR;
                        ev.data  = {24'd0, i_cmd_byte};
                    end
                end
                PH_TRI_PAY, PH_QUAD_PAY: begin
                    n_rem = rem_dec;
                    if (rem_dec == 23'd0) begin
                        push    = 1'b1;
                        ev.kind = (r_phase == PH_TRI_PAY) ? EV_TRI : EV_QUAD;
                        ev.fmt  = r_hdr[18:16];
                        ev.cnt  = r_hdr[15:0];
                        n_phase = PH_IDLE;
                        n_pos   = '0;
                        n_hdr   = '0;
                    end
                end
                PH_BP: begin
                    n_hdr = hdr_sh;
                    n_pos = pos_inc;
                    if (pos_inc >= 3'd4) begin
                        push    = 1'b1;
                        ev.kind = EV_BP;
                        ev.addr = {8'd0, hdr_sh[31:24]};
                        ev.data = {8'd0, hdr_sh[23:0]};
                        n_phase = PH_IDLE;
                        n_pos   = '0;
                        n_hdr   = '0;
                    end
                end
                PH_CP: begin
                    n_hdr = hdr_sh;
                    n_pos = pos_inc;
                    if (pos_inc >= 3'd5) begin
                        push    = 1'b1;
                        cp_done = 1'b1;
                        ev.kind = EV_CP;
                        ev.addr = {8'd0, cp_idx};
                        ev.data = hdr_sh[31:0];
                        n_phase = PH_IDLE;
                        n_pos   = '0;
                        n_hdr   = '0;
                    end
                end
                PH_XF_HDR: begin
                    n_hdr = hdr_sh;
                    n_pos = pos_inc;
                    if (pos_inc >= 3'd4) begin
                        n_left  = {1'b0, hdr_sh[19:16]} + 5'd1;
                        n_xaddr = hdr_sh[15:0];
                        n_phase = PH_XF_DATA;
                        n_pos   = '0;
                        n_hdr   = '0;
                    end
                end
                PH_XF_DATA: begin
                    n_hdr = hdr_sh;
                    n_pos = pos_inc;
                    if (pos_inc >= 3'd4) begin
                        push    = 1'b1;
                        ev.kind = EV_XF;
                        ev.addr = r_xaddr;
                        ev.data = hdr_sh[31:0];
                        n_xaddr = r_xaddr + 16'd1;
                        n_left  = left_dec;
                        n_pos   = '0;
                        n_hdr   = '0;
                        if (left_dec == 5'd0) n_phase = PH_IDLE;
                    end
                end
                PH_TRI_HDR, PH_QUAD_HDR: begin
                    n_hdr = hdr_sh;
                    n_pos = pos_inc;
                    if (pos_inc >= 3'd2) begin
                        if (total == 23'd0) begin
                            push    = 1'b1;
                            ev.kind = (r_phase == PH_TRI_HDR) ? EV_TRI : EV_QUAD;
                            ev.fmt  = hdr_sh[18:16];
                            ev.cnt  = hdr_sh[15:0];
                            n_phase = PH_IDLE;
                            n_pos   = '0;
                            n_hdr   = '0;
                        end else begin
                            n_rem   = total;
                            n_phase = (r_phase == PH_TRI_HDR) ? PH_TRI_PAY : PH_QUAD_PAY;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_pos   = '0;
                    n_hdr   = '0;
                end
            endcase
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_hdr    <= '0;
            r_pos    <= '0;
            r_rem    <= '0;
            r_left   <= '0;
            r_xaddr  <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hdr    <= n_hdr;
            r_pos    <= n_pos;
            r_rem    <= n_rem;
            r_left   <= n_left;
            r_xaddr  <= n_xaddr;
            r_halted <= n_halted;
        end
    end

    // vertex register writes, size recomputed in the cycle after the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_desc1[i] <= '0;
                r_desc2[i] <= '0;
                r_attr[i]  <= '0;
                r_vsize[i] <= '0;
            end
            r_recalc     <= 1'b0;
            r_recalc_fmt <= '0;
        end else begin
            r_recalc <= 1'b0;
            if (cp_done && !cp_idx[3]) begin
                unique case (cp_idx[7:4])
                    4'h5: r_desc1[cp_idx[2:0]] <= hdr_sh[31:0];
                    4'h6: r_desc2[cp_idx[2:0]] <= hdr_sh[31:0];
                    4'h7: r_attr[cp_idx[2:0]]  <= hdr_sh[31:0];
                    default: ;
                endcase
                if (cp_idx[7:4] == 4'h5 || cp_idx[7:4] == 4'h6 || cp_idx[7:4] == 4'h7) begin
                    r_recalc     <= 1'b1;
                    r_recalc_fmt <= cp_idx[2:0];
                end
            end
            if (r_recalc)
                r_vsize[r_recalc_fmt] <= f_vertex_bytes(r_desc1[r_recalc_fmt],
                                                        r_desc2[r_recalc_fmt],
                                                        r_attr[r_recalc_fmt]);
        end
    end

    assign o_push          = push;
    assign o_event         = ev;
    assign o_status.halted = r_halted;
    assign o_status.push   = push;
    assign o_status.err    = push && (ev.kind == EV_ERR);

endmodule

/* sv/gcsp_queue.sv */
module gcsp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gcsp_pkg::t_event i_event,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output gcsp_pkg::t_event o_event,
    output logic [1:0]       o_count
);
    import gcsp_pkg::*;

    t_event     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_push && o_space;
    assign pop     = o_valid && i_ready;
    assign o_event = r_mem[r_rp];
    assign o_count = r_cnt;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_event;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

/* sv/graphics_command_stream_parser.sv */
// graphics command stream parser
// input channel: one command byte per item on i_cmd_byte (i_valid / o_ready)
// output channel: one result item per register write, finished draw or
// unknown opcode on o_event_kind, o_reg_address, o_reg_data, o_format_index,
// o_vertex_count (o_valid / i_ready)
// one byte is taken every cycle while the two-entry result queue has room
// a result is written into the queue as the byte that completes it is taken
// the front parser decodes each byte as it is taken; vertex sizes are
// recomputed in the cycle after a vertex descriptor or attribute write
// draw payload bytes are counted and dropped
// reset clears the parser, the vertex registers, the size cache and the
// queue; an unknown opcode gives an error item, then every byte is
// taken and ignored until reset
// when the receiver stalls the queue fills and o_ready drops after two
// pending results; no item is lost
module graphics_command_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_cmd_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [15:0] o_reg_address,
    output logic [31:0] o_reg_data,
    output logic [2:0]  o_format_index,
    output logic [15:0] o_vertex_count
);
    import gcsp_pkg::*;

    logic          space;
    logic          push;
    t_event        front_ev;
    t_event        out_ev;
    t_front_status status;
    logic [1:0]    count;

    // parser front
    gcsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_space    (space),
        .i_cmd_byte (i_cmd_byte),
        .o_ready    (o_ready),
        .o_push     (push),
        .o_event    (front_ev),
        .o_status   (status)
    );

    // result queue and output side
    gcsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (front_ev),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_event (out_ev),
        .o_count (count)
    );

    assign o_event_kind   = out_ev.kind;
    assign o_reg_address  = out_ev.addr;
    assign o_reg_data     = out_ev.data;
    assign o_format_index = out_ev.fmt;
    assign o_vertex_count = out_ev.cnt;

    // checks
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.halted |-> !status.push)
        else $error("result pushed while halted");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.err |=> status.halted)
        else $error("error did not halt parser");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count != 2'd3)
        else $error("queue count overflow");

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.push |-> space)
        else $error("push into full queue");

endmodule
